// ===== hw/rtl/fbce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbce_pkg
// Shared types and constants of the block chain allocator: table geometry,
// link codes, command codes and the request and result bundles.
// ----------------------------------------------------------------------------
package fbce_pkg;

    // table geometry
    localparam int BLOCKS = 1024;
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int LINK_W = 16;
    localparam int BYTE_W = 8;

    // link table entry codes
    localparam logic [LINK_W-1:0] CODE_FREE = 16'hFFFE;
    localparam logic [LINK_W-1:0] CODE_END  = 16'hFFFF;

    // step and scan counter limit
    localparam logic [BLK_W-1:0] CNT_MAX = BLK_W'(BLOCKS - 1);

    // command codes
    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_APPEND = 2'd1,
        OP_FREE   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // link table port request
    typedef struct packed {
        logic              we;
        logic [BLK_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
        logic [BLK_W-1:0]  raddr;
    } t_link_req;

    // byte store port request
    typedef struct packed {
        logic              we;
        logic [BLK_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BLK_W-1:0]  raddr;
    } t_data_req;

    // one result beat
    typedef struct packed {
        logic              status;
        logic [BLK_W-1:0]  block_index;
        logic [BYTE_W-1:0] byte_out;
        logic [BLK_W-1:0]  next_index;
        logic              is_end;
    } t_result;

    // entry holds the number of a next block
    function automatic logic is_link(input logic [LINK_W-1:0] e);
        return e < LINK_W'(BLOCKS);
    endfunction

endpackage

// ===== hw/rtl/fat_block_chain_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_block_chain_engine_unit
// Block chain allocator over a link table and a byte store, one command
// per beat, with a registered result channel.
// ----------------------------------------------------------------------------
// Usage
//   Command channel i_valid/o_ready carries opcode, chain_start, chain_end
//   and data_byte; result channel o_valid/i_ready carries status,
//   block_index, byte_out, next_index and is_end. Every command gives one
//   result beat.
//   All work goes through one link table port; each step of the walk and scan
//   loops has a read state and an evaluate state. New scans up from block 0,
//   append walks the chain and then scans past its end, free walks the
//   blocks that it frees, read looks at one entry.
//   Commands are taken one at a time; o_ready is low while one runs.
//   After reset the link table is swept to free, one entry per cycle;
//   o_ready stays low during the sweep.
//   A finished result sits in the output register; the next command is
//   accepted while it waits, and that command holds its own result back
//   until i_ready frees the register.
// ----------------------------------------------------------------------------
module fat_block_chain_engine_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [fbce_pkg::BLK_W-1:0]    i_chain_start,
    input  logic [fbce_pkg::BLK_W-1:0]    i_chain_end,
    input  logic [fbce_pkg::BYTE_W-1:0]   i_data_byte,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic [fbce_pkg::BLK_W-1:0]    o_block_index,
    output logic [fbce_pkg::BYTE_W-1:0]   o_byte_out,
    output logic [fbce_pkg::BLK_W-1:0]    o_next_index,
    output logic                          o_is_end
);

    import fbce_pkg::*;

    t_link_req         link_req;
    t_data_req         data_req;
    logic [LINK_W-1:0] link_rdata;
    logic [BYTE_W-1:0] data_rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           result;

    logic              r_o_valid;
    t_result           r_out;

    // sequencer
    fbce_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_chain_start (i_chain_start),
        .i_chain_end   (i_chain_end),
        .i_data_byte   (i_data_byte),
        .o_link_req    (link_req),
        .i_link_rdata  (link_rdata),
        .o_data_req    (data_req),
        .i_data_rdata  (data_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_result      (result)
    );

    // link table
    fbce_ram #(
        .WIDTH (LINK_W),
        .DEPTH (BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_req.we),
        .i_waddr (link_req.waddr),
        .i_wdata (link_req.wdata),
        .i_raddr (link_req.raddr),
        .o_rdata (link_rdata)
    );

    // byte store
    fbce_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BLOCKS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_req.we),
        .i_waddr (data_req.waddr),
        .i_wdata (data_req.wdata),
        .i_raddr (data_req.raddr),
        .o_rdata (data_rdata)
    );

    // output register, free when empty or being drained
    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= result;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_out.status;
    assign o_block_index = r_out.block_index;
    assign o_byte_out    = r_out.byte_out;
    assign o_next_index  = r_out.next_index;
    assign o_is_end      = r_out.is_end;

endmodule

// ===== hw/rtl/fbce_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbce_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module fbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fbce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbce_ctrl
// Command sequencer: clears the link table after reset, then walks chains,
// scans for free blocks and rewrites links, one command at a time.
// ----------------------------------------------------------------------------
module fbce_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [fbce_pkg::BLK_W-1:0]          i_chain_start,
    input  logic [fbce_pkg::BLK_W-1:0]          i_chain_end,
    input  logic [fbce_pkg::BYTE_W-1:0]         i_data_byte,
    // table ports
    output fbce_pkg::t_link_req                 o_link_req,
    input  logic [fbce_pkg::LINK_W-1:0]         i_link_rdata,
    output fbce_pkg::t_data_req                 o_data_req,
    input  logic [fbce_pkg::BYTE_W-1:0]         i_data_rdata,
    // result handoff
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output fbce_pkg::t_result                   o_result
);

    import fbce_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_WALK_RD   = 13'b0000000000100,
        S_WALK_EV   = 13'b0000000001000,
        S_SCAN_RD   = 13'b0000000010000,
        S_SCAN_EV   = 13'b0000000100000,
        S_APP_END   = 13'b0000001000000,
        S_FREE_RD   = 13'b0000010000000,
        S_FREE_EV   = 13'b0000100000000,
        S_FREE_LAST = 13'b0001000000000,
        S_READ_RD   = 13'b0010000000000,
        S_READ_EV   = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [BLK_W-1:0]  r_cnt,   n_cnt;
    t_op               r_op,    n_op;
    logic [BLK_W-1:0]  r_p,     n_p;
    logic [BLK_W-1:0]  r_last,  n_last;
    logic [BYTE_W-1:0] r_byte,  n_byte;
    logic [BLK_W-1:0]  r_scan,  n_scan;
    logic              r_fail,  n_fail;
    logic [BYTE_W-1:0] r_rbyte, n_rbyte;
    logic [BLK_W-1:0]  r_rnext, n_rnext;
    logic              r_rend,  n_rend;

    logic [BLK_W-1:0]  scan_lim;

    // new chain tries every block, append every block but its own end
    assign scan_lim = (r_op == OP_NEW) ? CNT_MAX : CNT_MAX - BLK_W'(1);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_p     = r_p;
        n_last  = r_last;
        n_byte  = r_byte;
        n_scan  = r_scan;
        n_fail  = r_fail;
        n_rbyte = r_rbyte;
        n_rnext = r_rnext;
        n_rend  = r_rend;

        o_link_req       = '0;
        o_link_req.raddr = (r_state == S_SCAN_RD) ? r_scan : r_p;
        o_data_req       = '0;
        o_data_req.raddr = r_p;

        case (r_state)
            // sweep the link table to free after reset
            S_CLEAR: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_cnt;
                o_link_req.wdata = CODE_FREE;
                n_cnt            = r_cnt + BLK_W'(1);
                if (r_cnt == CNT_MAX) begin
                    n_state = S_IDLE;
                end
            end

            // take a command beat
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = t_op'(i_opcode);
                    n_p     = i_chain_start;
                    n_last  = i_chain_end;
                    n_byte  = i_data_byte;
                    n_cnt   = '0;
                    n_scan  = '0;
                    n_fail  = 1'b0;
                    n_rbyte = '0;
                    n_rnext = '0;
                    n_rend  = 1'b0;
                    case (t_op'(i_opcode))
                        OP_NEW:    n_state = S_SCAN_RD;
                        OP_APPEND: n_state = S_WALK_RD;
                        OP_FREE:   n_state = S_FREE_RD;
                        OP_READ:   n_state = S_READ_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end

            // chain walk to the end block
            S_WALK_RD: begin
                n_state = S_WALK_EV;
            end

            S_WALK_EV: begin
                if (is_link(i_link_rdata) && r_cnt != CNT_MAX) begin
                    n_p     = i_link_rdata[BLK_W-1:0];
                    n_cnt   = r_cnt + BLK_W'(1);
                    n_state = S_WALK_RD;
                end else begin
                    if (is_link(i_link_rdata)) begin
                        n_p = i_link_rdata[BLK_W-1:0];
                    end
                    n_scan  = n_p + BLK_W'(1);
                    n_cnt   = '0;
                    n_state = S_SCAN_RD;
                end
            end

            // free block scan, wrapping past the top
            S_SCAN_RD: begin
                n_state = S_SCAN_EV;
            end

            S_SCAN_EV: begin
                if (i_link_rdata == CODE_FREE) begin
                    if (r_op == OP_NEW) begin
                        o_link_req.we    = 1'b1;
                        o_link_req.waddr = r_scan;
                        o_link_req.wdata = CODE_END;
                        n_state          = S_DONE;
                    end else begin
                        o_link_req.we    = 1'b1;
                        o_link_req.waddr = r_p;
                        o_link_req.wdata = LINK_W'(r_scan);
                        o_data_req.we    = 1'b1;
                        o_data_req.waddr = r_p;
                        o_data_req.wdata = r_byte;
                        n_state          = S_APP_END;
                    end
                end else if (r_cnt == scan_lim) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_scan  = r_scan + BLK_W'(1);
                    n_cnt   = r_cnt + BLK_W'(1);
                    n_state = S_SCAN_RD;
                end
            end

            // mark the new block as the chain end
            S_APP_END: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_scan;
                o_link_req.wdata = CODE_END;
                n_state          = S_DONE;
            end

            // free walk up to the last block
            S_FREE_RD: begin
                if (r_p == r_last) begin
                    n_state = S_FREE_LAST;
                end else begin
                    n_state = S_FREE_EV;
                end
            end

            S_FREE_EV: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_p;
                o_link_req.wdata = CODE_FREE;
                if (is_link(i_link_rdata) && r_cnt != CNT_MAX) begin
                    n_p     = i_link_rdata[BLK_W-1:0];
                    n_cnt   = r_cnt + BLK_W'(1);
                    n_state = S_FREE_RD;
                end else begin
                    n_state = S_FREE_LAST;
                end
            end

            S_FREE_LAST: begin
                o_link_req.we    = 1'b1;
                o_link_req.waddr = r_last;
                o_link_req.wdata = CODE_FREE;
                n_state          = S_DONE;
            end

            // single block read
            S_READ_RD: begin
                n_state = S_READ_EV;
            end

            S_READ_EV: begin
                if (i_link_rdata == CODE_END) begin
                    n_rend = 1'b1;
                end else if (is_link(i_link_rdata)) begin
                    n_rbyte = i_data_rdata;
                    n_rnext = i_link_rdata[BLK_W-1:0];
                end
                n_state = S_DONE;
            end

            // hand the result to the output register
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_p     <= n_p;
        r_last  <= n_last;
        r_byte  <= n_byte;
        r_scan  <= n_scan;
        r_fail  <= n_fail;
        r_rbyte <= n_rbyte;
        r_rnext <= n_rnext;
        r_rend  <= n_rend;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    // result fields
    always_comb begin
        o_result             = '0;
        o_result.status      = r_fail;
        o_result.byte_out    = r_rbyte;
        o_result.next_index  = r_rnext;
        o_result.is_end      = r_rend;
        if (!r_fail && (r_op == OP_NEW || r_op == OP_APPEND)) begin
            o_result.block_index = r_scan;
        end
    end

endmodule

// ===== bench/tb_fat_block_chain_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fat_block_chain_engine_unit
// Self-checking bench for the block chain allocator. A scoreboard class keeps
// its own link table and byte store, predicts the result of every accepted
// command and checks each result beat against it in order. Stimulus runs a
// directed pass, then well-formed chain traffic mixed with noise under
// several sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_fat_block_chain_engine_unit;
    import fbce_pkg::*;

    localparam int USABLE      = (BLOCKS < 'hFFFE) ? BLOCKS : 'hFFFE;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int MAX_LIVE    = 12;
    localparam int MAX_LEN     = 10;
    localparam int DRAIN_CYCLES = 100;
    localparam int PRINT_CAP   = 40;

    // allocator shadow and expected result queue
    class chain_scoreboard;
        logic [LINK_W-1:0] links [BLOCKS];
        logic [BYTE_W-1:0] bytes [BLOCKS];
        t_result           pending [$];
        int                errors;

        function new();
            foreach (links[i]) begin
                links[i] = CODE_FREE;
                bytes[i] = '0;
            end
            errors = 0;
        endfunction

        // lowest free block at or above from, then below it, never skip
        function int find_free(int from, int skip);
            for (int i = from; i < USABLE; i++)
                if (i != skip && links[i] == CODE_FREE)
                    return i;
            for (int i = 0; i < from && i < USABLE; i++)
                if (i != skip && links[i] == CODE_FREE)
                    return i;
            return -1;
        endfunction

        // follow links from p for at most max_steps, stop at a non-link entry
        function int chain_walk(int p, int max_steps, output int steps);
            int e;
            steps = 0;
            while (steps < max_steps) begin
                e = links[p];
                if (e >= USABLE)
                    break;
                p = e;
                steps++;
            end
            return p;
        endfunction

        // apply one accepted command and queue its expected result
        function t_result note_command(t_op op, logic [BLK_W-1:0] start,
                                       logic [BLK_W-1:0] last,
                                       logic [BYTE_W-1:0] data);
            t_result r;
            int b, p, n, e, s, l;
            r = '0;
            s = int'(start) % BLOCKS;
            l = int'(last) % BLOCKS;
            case (op)
                OP_NEW: begin
                    b = find_free(0, -1);
                    if (b < 0) begin
                        r.status = 1'b1;
                    end else begin
                        links[b] = CODE_END;
                        r.block_index = BLK_W'(b);
                    end
                end
                OP_APPEND: begin
                    p = chain_walk(s, BLOCKS, n);
                    b = find_free(p + 1, p);
                    if (b < 0) begin
                        r.status = 1'b1;
                    end else begin
                        bytes[p] = data;
                        links[p] = LINK_W'(b);
                        links[b] = CODE_END;
                        r.block_index = BLK_W'(b);
                    end
                end
                OP_FREE: begin
                    p = s;
                    n = 0;
                    while (n < BLOCKS && p != l) begin
                        e = links[p];
                        links[p] = CODE_FREE;
                        if (e >= USABLE)
                            break;
                        p = e;
                        n++;
                    end
                    links[l] = CODE_FREE;
                end
                default: begin
                    e = links[s];
                    if (links[s] == CODE_END) begin
                        r.is_end = 1'b1;
                    end else if (e < USABLE) begin
                        r.byte_out   = bytes[s];
                        r.next_index = BLK_W'(e);
                    end
                end
            endcase
            pending.insert(pending.size(), r);
            return r;
        endfunction

        // print one mismatch line (capped) and count it
        task report(string what, int got_v, int want_v);
            if (errors < PRINT_CAP)
                $display("mismatch %s: got %0d, expected %0d at %0t",
                         what, got_v, want_v, $realtime);
            errors++;
        endtask

        // compare a result beat with the oldest expectation
        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("unexpected beat, block_index", got.block_index, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.block_index !== want.block_index)
                report("block_index", got.block_index, want.block_index);
            if (got.byte_out !== want.byte_out)
                report("byte_out", got.byte_out, want.byte_out);
            if (got.next_index !== want.next_index)
                report("next_index", got.next_index, want.next_index);
            if (got.is_end !== want.is_end)
                report("is_end", got.is_end, want.is_end);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_opcode;
    logic [BLK_W-1:0]    i_chain_start;
    logic [BLK_W-1:0]    i_chain_end;
    logic [BYTE_W-1:0]   i_data_byte;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_status;
    logic [BLK_W-1:0]    o_block_index;
    logic [BYTE_W-1:0]   o_byte_out;
    logic [BLK_W-1:0]    o_next_index;
    logic                o_is_end;

    chain_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  cycles = 0;
    int  live_heads [$];

    fat_block_chain_engine_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_chain_start (i_chain_start),
        .i_chain_end   (i_chain_end),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_byte_out    (o_byte_out),
        .o_next_index  (o_next_index),
        .o_is_end      (o_is_end)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result beat monitor
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.status      = o_status;
            got.block_index = o_block_index;
            got.byte_out    = o_byte_out;
            got.next_index  = o_next_index;
            got.is_end      = o_is_end;
            sb.check_result(got);
        end
    end

    // present one command beat, wait for acceptance, predict its result
    task issue(t_op op, logic [BLK_W-1:0] start, logic [BLK_W-1:0] last,
               logic [BYTE_W-1:0] data, output t_result r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_chain_start <= start;
        i_chain_end   <= last;
        i_data_byte   <= data;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        r = sb.note_command(op, start, last, data);
    endtask

    // one random command: mostly chain traffic, some noise
    task random_command();
        t_result r;
        int sel, pick, h, tail, len, k;
        logic [BLK_W-1:0] s;
        // drop chains whose head was freed
        for (k = live_heads.size() - 1; k >= 0; k--)
            if (sb.links[live_heads[k]] == CODE_FREE)
                live_heads.delete(k);
        pick = 0;
        h = 0;
        tail = 0;
        len = 0;
        if (live_heads.size() > 0) begin
            pick = $urandom_range(0, live_heads.size() - 1);
            h    = live_heads[pick];
            tail = sb.chain_walk(h, BLOCKS, len);
        end
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            issue(t_op'($urandom_range(0, 3)), BLK_W'($urandom_range(0, BLOCKS - 1)),
                  BLK_W'($urandom_range(0, BLOCKS - 1)), BYTE_W'($urandom_range(0, 255)),
                  r);
        end else if (live_heads.size() == 0 || (sel < 27 && live_heads.size() < MAX_LIVE)) begin
            issue(OP_NEW, BLK_W'($urandom_range(0, BLOCKS - 1)),
                  BLK_W'($urandom_range(0, BLOCKS - 1)), BYTE_W'($urandom_range(0, 255)),
                  r);
            if (!r.status)
                live_heads.insert(live_heads.size(), int'(r.block_index));
        end else if (sel < 62 && len < MAX_LEN) begin
            s = ($urandom_range(0, 3) == 0) ? BLK_W'(tail) : BLK_W'(h);
            issue(OP_APPEND, s, BLK_W'($urandom_range(0, BLOCKS - 1)),
                  BYTE_W'($urandom_range(0, 255)), r);
        end else if (sel < 77) begin
            issue(OP_FREE, BLK_W'(h), BLK_W'(tail), BYTE_W'($urandom_range(0, 255)), r);
            live_heads.delete(pick);
        end else begin
            if ($urandom_range(0, 1))
                s = BLK_W'(sb.chain_walk(h, $urandom_range(0, len), k));
            else
                s = BLK_W'($urandom_range(0, BLOCKS - 1));
            issue(OP_READ, s, BLK_W'($urandom_range(0, BLOCKS - 1)),
                  BYTE_W'($urandom_range(0, 255)), r);
        end
    endtask

    // main sequence
    initial begin
        t_result r;
        int n, ph;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_opcode      = OP_NEW;
        i_chain_start = '0;
        i_chain_end   = '0;
        i_data_byte   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every command, broken chains, odd frees
        issue(OP_NEW,    0,    0,    0,     r);
        issue(OP_APPEND, 0,    0,    8'hFF, r);
        issue(OP_APPEND, 0,    0,    8'h00, r);
        issue(OP_APPEND, 2,    0,    8'hA5, r);
        issue(OP_READ,   0,    0,    0,     r);
        issue(OP_READ,   1,    0,    0,     r);
        issue(OP_READ,   3,    0,    0,     r);
        issue(OP_READ,   1023, 1023, 8'hFF, r);
        issue(OP_NEW,    1023, 1023, 8'hFF, r);
        // append on a free top block wraps the scan to the bottom
        issue(OP_APPEND, 1023, 0,    8'h5A, r);
        issue(OP_READ,   1023, 0,    0,     r);
        issue(OP_FREE,   1023, 1023, 0,     r);
        // free stops early at the given end block
        issue(OP_FREE,   0,    2,    0,     r);
        issue(OP_READ,   2,    0,    0,     r);
        // end block outside the chain is freed as well
        issue(OP_FREE,   5,    0,    0,     r);
        issue(OP_FREE,   4,    4,    0,     r);
        issue(OP_FREE,   3,    3,    0,     r);
        issue(OP_FREE,   3,    3,    0,     r);
        issue(OP_APPEND, 0,    1023, 8'h3C, r);
        issue(OP_READ,   0,    1023, 8'hFF, r);
        issue(OP_FREE,   0,    1023, 8'hFF, r);
        issue(OP_READ,   1,    0,    0,     r);

        // random traffic under each stall pattern
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_command();
        end
        i_valid <= 1'b0;

        // drain outstanding results, then a quiet tail
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fbce_pkg.sv
hw/rtl/fbce_ram.sv
hw/rtl/fbce_ctrl.sv
hw/rtl/fat_block_chain_engine_unit.sv
bench/tb_fat_block_chain_engine_unit.sv
